@@ sv/text_window_console_unit_macros.svh @@
// Assertion macros for the console RTL.
// The macros sample on clk and are disabled while arst_n is low.
`ifndef TEXT_WINDOW_CONSOLE_UNIT_MACROS_SVH
`define TEXT_WINDOW_CONSOLE_UNIT_MACROS_SVH

// Same-cycle implication.
`define TWC_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TWC_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/twc_pkg.sv @@
// ----------------------------------------------------------------------------
// twc_pkg
// Types and constants shared by the text window console modules.
// ----------------------------------------------------------------------------
package twc_pkg;

	localparam logic [1:0] CMD_PRINT = 2'd0;
	localparam logic [1:0] CMD_BKSP  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_PEEK  = 2'd3;

	localparam logic [2:0] REG_LEFT = 3'd0;
	localparam logic [2:0] REG_TOP  = 3'd1;
	localparam logic [2:0] REG_COLS = 3'd2;
	localparam logic [2:0] REG_ROWS = 3'd3;
	localparam logic [2:0] REG_FONT = 3'd4;
	localparam logic [2:0] REG_ATTR = 3'd5;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_LOW_A   = 8'h61;
	localparam logic [7:0] CH_LOW_Z   = 8'h7A;
	localparam logic [7:0] CH_LAST    = 8'h7F;

	typedef struct packed {
		logic [4:0] left;
		logic [4:0] top;
		logic [5:0] cols;
		logic [5:0] rows;
		logic [7:0] font;
		logic [7:0] attr;
	} cfg_t;

	typedef struct packed {
		logic [4:0] peek_row;
		logic [4:0] peek_column;
		logic [7:0] char_byte;
		logic [1:0] cmd;
	} req_t;

	typedef struct packed {
		logic       success;
		logic [5:0] cursor_row;
		logic [4:0] cursor_column;
		logic [7:0] cell_attribute;
		logic [7:0] cell_glyph;
	} res_t;

endpackage

@@ sv/twc_cell_ram.sv @@
// ----------------------------------------------------------------------------
// twc_cell_ram
// Tile map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module twc_cell_ram #(
	parameter int AW = 5
) (
	input  logic            clk,
	input  logic            we,
	input  logic [2*AW-1:0] waddr,
	input  logic [15:0]     wdata,
	input  logic            re,
	input  logic [2*AW-1:0] raddr,
	output logic [15:0]     rdata
);
	logic [15:0] mem [2**(2*AW)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ sv/twc_seq.sv @@
// ----------------------------------------------------------------------------
// twc_seq
// Command sequencer: cursor state, map sweeps and cell memory access.
// ----------------------------------------------------------------------------
module twc_seq #(
	parameter int AW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  twc_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  twc_pkg::req_t req,
	input  logic          out_free,
	output logic          done,
	output twc_pkg::res_t res
);
	import twc_pkg::*;

	localparam int SIDE = 2 ** AW;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_SCRL_RD, S_SCRL_WR, S_FILL, S_EXEC,
		S_BS1, S_BS2, S_CLR, S_PEEK, S_DONE
	} state_t;

	state_t          state_q;
	logic [2*AW-1:0] init_q;
	logic [AW-1:0]   x_q, y_q;
	logic [AW-1:0]   col_q;
	logic [AW:0]     row_q;
	logic            ok_q;
	req_t            req_q;
	logic [15:0]     peek_q;

	logic [AW:0]     w, h, wm1, hm1, hm2;
	logic [AW-1:0]   left_a, top_a;
	logic            we, re;
	logic [2*AW-1:0] waddr, raddr;
	logic [15:0]     wdata, rdata;
	logic [7:0]      glyph_c, fold_c;
	logic            printable, newline;
	logic [AW:0]     ncol, nrow;
	logic            x_last;

	always_comb begin
		if (cfg.cols == '0) begin
			w = (AW+1)'(1);
		end else if ({1'b0, cfg.cols} > 7'(SIDE)) begin
			w = (AW+1)'(SIDE);
		end else begin
			w = (AW+1)'(cfg.cols);
		end
		if (cfg.rows == '0) begin
			h = (AW+1)'(1);
		end else if ({1'b0, cfg.rows} > 7'(SIDE)) begin
			h = (AW+1)'(SIDE);
		end else begin
			h = (AW+1)'(cfg.rows);
		end
	end

	assign wm1    = w - (AW+1)'(1);
	assign hm1    = h - (AW+1)'(1);
	assign hm2    = h - (AW+1)'(2);
	assign left_a = AW'(cfg.left);
	assign top_a  = AW'(cfg.top);
	assign x_last = ({1'b0, x_q} == wm1);

	// Character decode for a print.
	assign printable = (req_q.char_byte >= CH_SPACE) && (req_q.char_byte <= CH_LAST);
	assign newline   = (req_q.char_byte == CH_NEWLINE);
	assign fold_c    = ((req_q.char_byte >= CH_LOW_A) && (req_q.char_byte <= CH_LOW_Z))
		? req_q.char_byte - CH_SPACE : req_q.char_byte;
	assign glyph_c   = cfg.font + (fold_c - CH_SPACE);

	always_comb begin
		ncol = {1'b0, col_q};
		nrow = row_q;
		if (printable) begin
			ncol = {1'b0, col_q} + (AW+1)'(1);
		end else if (newline) begin
			ncol = '0;
			nrow = row_q + (AW+1)'(1);
		end
		if (ncol >= w) begin
			ncol = '0;
			nrow = nrow + (AW+1)'(1);
		end
	end

	// Memory port control.
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = '0;
		raddr = '0;
		wdata = {cfg.attr, cfg.font};
		case (state_q)
			S_INIT: begin
				we    = 1'b1;
				waddr = init_q;
				wdata = '0;
			end
			S_IDLE: begin
				re    = in_valid && (req.cmd == CMD_PEEK);
				raddr = {AW'(req.peek_row), AW'(req.peek_column)};
			end
			S_SCRL_RD: begin
				re    = 1'b1;
				raddr = {top_a + y_q + AW'(1), left_a + x_q};
			end
			S_SCRL_WR: begin
				we    = 1'b1;
				waddr = {top_a + y_q, left_a + x_q};
				wdata = rdata;
			end
			S_FILL: begin
				we    = 1'b1;
				waddr = {top_a + AW'(hm1), left_a + x_q};
			end
			S_EXEC: begin
				we    = printable;
				waddr = {top_a + AW'(row_q), left_a + col_q};
				wdata = {cfg.attr, glyph_c};
			end
			S_BS1, S_BS2: begin
				we    = 1'b1;
				waddr = {top_a + AW'(row_q), left_a + col_q};
			end
			S_CLR: begin
				we    = 1'b1;
				waddr = {top_a + y_q, left_a + x_q};
			end
			default: begin
			end
		endcase
	end

	twc_cell_ram #(.AW(AW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign in_ready = (state_q == S_IDLE);
	assign done     = (state_q == S_DONE) && out_free;

	always_comb begin
		res                = '0;
		res.cursor_column  = 5'(col_q);
		res.cursor_row     = 6'(row_q);
		res.success        = ok_q;
		if (req_q.cmd == CMD_PEEK) begin
			res.cell_glyph     = peek_q[7:0];
			res.cell_attribute = peek_q[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q  <= '0;
			x_q     <= '0;
			y_q     <= '0;
			col_q   <= '0;
			row_q   <= '0;
			ok_q    <= 1'b1;
			req_q   <= '0;
			peek_q  <= '0;
		end else begin
			case (state_q)
				S_INIT: begin
					init_q <= init_q + (2*AW)'(1);
					if (&init_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q <= req;
						ok_q  <= 1'b1;
						x_q   <= '0;
						y_q   <= '0;
						case (req.cmd)
							CMD_PRINT: begin
								if (req.char_byte == '0) begin
									state_q <= S_DONE;
								end else if (row_q >= h) begin
									state_q <= (h == (AW+1)'(1)) ? S_FILL : S_SCRL_RD;
								end else begin
									state_q <= S_EXEC;
								end
							end
							CMD_BKSP:  state_q <= S_BS1;
							CMD_CLEAR: begin
								col_q   <= '0;
								row_q   <= '0;
								state_q <= S_CLR;
							end
							default:   state_q <= S_PEEK;
						endcase
					end
				end
				S_SCRL_RD: state_q <= S_SCRL_WR;
				S_SCRL_WR: begin
					state_q <= S_SCRL_RD;
					if (x_last) begin
						x_q <= '0;
						if ({1'b0, y_q} == hm2) begin
							state_q <= S_FILL;
						end else begin
							y_q <= y_q + AW'(1);
						end
					end else begin
						x_q <= x_q + AW'(1);
					end
				end
				S_FILL: begin
					if (x_last) begin
						row_q   <= hm1;
						state_q <= S_EXEC;
					end else begin
						x_q <= x_q + AW'(1);
					end
				end
				S_EXEC: begin
					col_q   <= AW'(ncol);
					row_q   <= nrow;
					state_q <= S_DONE;
				end
				S_BS1: begin
					state_q <= S_BS2;
					if (col_q != '0) begin
						col_q <= col_q - AW'(1);
					end else if (row_q != '0) begin
						col_q <= AW'(wm1);
						row_q <= row_q - (AW+1)'(1);
					end else begin
						ok_q    <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_BS2: state_q <= S_DONE;
				S_CLR: begin
					if (x_last) begin
						x_q <= '0;
						if ({1'b0, y_q} == hm1) begin
							state_q <= S_DONE;
						end else begin
							y_q <= y_q + AW'(1);
						end
					end else begin
						x_q <= x_q + AW'(1);
					end
				end
				S_PEEK: begin
					peek_q  <= rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`include "text_window_console_unit_macros.svh"

	`TWC_ASSERT_IMP(a_no_rw_clash, we && re, waddr != raddr, "read and write hit one cell")
	`TWC_ASSERT_NXT(a_done_idle, done, state_q == S_IDLE, "sequencer not idle after result")
	`TWC_ASSERT_NXT(a_peek_read, state_q == S_IDLE && in_valid && req.cmd == CMD_PEEK,
		state_q == S_PEEK, "cell read not started")
	`TWC_ASSERT_IMP(a_fail_corner, done && !res.success,
		col_q == '0 && row_q == '0, "backspace failed away from the corner")

endmodule

@@ sv/text_window_console_unit.sv @@
// ----------------------------------------------------------------------------
// text_window_console_unit
// Text console drawn into a square tile map of glyph and attribute bytes.
//
//   Channel  Direction  Contents (lowest bits first)
//   s_*      in         cmd[1:0], char_byte[7:0], peek_column[4:0], peek_row[4:0]
//   m_*      out        cell_glyph, cell_attribute, cursor_column, cursor_row, success
//   cfg_*    in         register writes, index 0..5, no read-back
//
// A print of a plain byte runs S_EXEC then S_DONE, a cell read S_PEEK then
// S_DONE. A backspace blanks the cursor cell and, if it moves, the cell it
// lands on. A scroll moves each window row below the top up one row, each
// cell read and then written, then blanks the bottom row; a clear blanks
// every window cell. The cell memory has one port per direction. After
// reset the map is zeroed while s_tready stays low. A finished result
// waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module text_window_console_unit #(
	parameter int MAP_SIDE = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // cmd, char_byte, peek_column, peek_row, zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // cell_glyph, cell_attribute, cursor_column,
	                               // cursor_row, success, zero fill
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import twc_pkg::*;

	localparam int AW = $clog2(MAP_SIDE);

	cfg_t cfg_q;
	res_t res, res_q;
	logic out_free, done;

	// Configuration registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left <= 5'd0;
			cfg_q.top  <= 5'd0;
			cfg_q.cols <= 6'd20;
			cfg_q.rows <= 6'd16;
			cfg_q.font <= 8'd0;
			cfg_q.attr <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT: cfg_q.left <= cfg_data[4:0];
				REG_TOP:  cfg_q.top  <= cfg_data[4:0];
				REG_COLS: cfg_q.cols <= cfg_data[5:0];
				REG_ROWS: cfg_q.rows <= cfg_data[5:0];
				REG_FONT: cfg_q.font <= cfg_data;
				REG_ATTR: cfg_q.attr <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The sequencer hands over a result only when this register can take it.
	assign out_free = !m_tvalid || m_tready;

	twc_seq #(.AW(AW)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.req      (req_t'(s_tdata[19:0])),
		.out_free (out_free),
		.done     (done),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (done) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res;
		end
	end

	assign m_tdata = {4'd0, res_q};

endmodule

@@ dv/text_window_console_unit_test.sv @@
// ----------------------------------------------------------------------------
// text_window_console_unit_test
// Self-checking bench for the text window console. A queue of requests feeds
// a clocked driver, and a clocked monitor compares every result with a
// prediction made when its request was accepted. Register settings change
// between phases, only while the console is idle.
// ----------------------------------------------------------------------------
module text_window_console_unit_test;
	import twc_pkg::*;

	logic        clk = 1'b1;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // cmd, char_byte, peek_column, peek_row, zero fill
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // cell_glyph, cell_attribute, cursor_column,
	                             // cursor_row, success, zero fill
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	text_window_console_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Clock with a period of two time units.
	always begin
		#1 clk = 1'b0;
		#1 clk = 1'b1;
	end

	// Predicted console state: the map, the cursor and the register file.
	logic [15:0] map_cells [1024];
	int          cur_col, cur_row;
	cfg_t        regs;

	req_t pending_requests [$];
	res_t expected_results [$];
	req_t in_flight;
	int   mismatches = 0;
	bit   no_idle = 1'b0;    // when set, neither side inserts gaps

	function automatic int clamp_size(logic [5:0] v);
		if (v == 0) return 1;
		if (v > 32) return 32;
		return int'(v);
	endfunction

	function automatic int map_addr(int col, int row);
		return (row & 31) * 32 + (col & 31);
	endfunction

	// Writes one cell at a position relative to the window's corner.
	function automatic void write_window_cell(int col, int row, logic [7:0] glyph);
		map_cells[map_addr(regs.left + col, regs.top + row)] = {regs.attr, glyph};
	endfunction

	// Applies one request to the predicted state and returns its result.
	function automatic res_t console_apply(req_t r);
		res_t       res;
		int         w, h, c;
		logic [15:0] v;
		w = clamp_size(regs.cols);
		h = clamp_size(regs.rows);
		res = '0;
		res.success = 1'b1;
		case (r.cmd)
			CMD_PRINT: begin
				if (r.char_byte != 0) begin
					// A pending scroll moves the window up one row first.
					if (cur_row >= h) begin
						for (int y = 0; y + 1 < h; y++)
							for (int x = 0; x < w; x++)
								map_cells[map_addr(regs.left + x, regs.top + y)] =
									map_cells[map_addr(regs.left + x, regs.top + y + 1)];
						for (int x = 0; x < w; x++)
							write_window_cell(x, h - 1, regs.font);
						cur_row = h - 1;
					end
					if (r.char_byte >= CH_SPACE && r.char_byte <= CH_LAST) begin
						c = int'(r.char_byte);
						if (r.char_byte >= CH_LOW_A && r.char_byte <= CH_LOW_Z)
							c -= 32;
						write_window_cell(cur_col, cur_row, regs.font + 8'(c - 32));
						cur_col++;
					end else if (r.char_byte == CH_NEWLINE) begin
						cur_col = 0;
						cur_row++;
					end
					if (cur_col >= w) begin
						cur_col = 0;
						cur_row++;
					end
				end
			end
			CMD_BKSP: begin
				write_window_cell(cur_col, cur_row, regs.font);
				if (cur_col > 0) begin
					cur_col--;
				end else if (cur_row > 0) begin
					cur_col = w - 1;
					cur_row--;
				end else begin
					res.success = 1'b0;
				end
				if (res.success)
					write_window_cell(cur_col, cur_row, regs.font);
			end
			CMD_CLEAR: begin
				cur_col = 0;
				cur_row = 0;
				for (int y = 0; y < h; y++)
					for (int x = 0; x < w; x++)
						write_window_cell(x, y, regs.font);
			end
			default: begin
				v = map_cells[map_addr(r.peek_column, r.peek_row)];
				res.cell_glyph = v[7:0];
				res.cell_attribute = v[15:8];
			end
		endcase
		res.cursor_column = 5'(cur_col);
		res.cursor_row = 6'(cur_row);
		return res;
	endfunction

	// Driver: presents queued requests, with a random gap after each one unless no_idle is set.
	logic [1:0] send_gap = '0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= '0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(console_apply(in_flight));
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 2'd1;
					s_tvalid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					in_flight = pending_requests.pop_front();
					s_tdata <= {4'b0, in_flight};
					s_tvalid <= 1'b1;
					send_gap <= no_idle ? 2'd0 : 2'($urandom_range(0, 3));
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result and stalls the result side at random unless no_idle is set.
	logic [1:0] recv_stall = '0;
	always @(posedge clk or negedge arst_n) begin
		res_t got, want;
		logic [1:0] n;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall <= '0;
		end else if (m_tvalid && m_tready) begin
			got = res_t'(m_tdata[27:0]);
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result %h", got);
			end else begin
				want = expected_results.pop_front();
				if (got.cell_glyph !== want.cell_glyph ||
				    got.cell_attribute !== want.cell_attribute ||
				    got.cursor_column !== want.cursor_column ||
				    got.cursor_row !== want.cursor_row ||
				    got.success !== want.success) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: exp/act glyph %h/%h attr %h/%h col %0d/%0d",
							want.cell_glyph, got.cell_glyph,
							want.cell_attribute, got.cell_attribute,
							want.cursor_column, got.cursor_column,
							" row %0d/%0d ok %b/%b",
							want.cursor_row, got.cursor_row,
							want.success, got.success);
				end
			end
			n = no_idle ? 2'd0 : 2'($urandom_range(0, 3));
			recv_stall <= n;
			m_tready <= (n == 0);
		end else if (recv_stall != 0) begin
			recv_stall <= recv_stall - 2'd1;
			m_tready <= (recv_stall == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic req_t make_request(logic [1:0] cmd, logic [7:0] ch,
		logic [4:0] col, logic [4:0] row);
		req_t r;
		r.cmd = cmd;
		r.char_byte = ch;
		r.peek_column = col;
		r.peek_row = row;
		return r;
	endfunction

	// Mostly prints of text and newlines, with backspaces, clears and reads.
	function automatic req_t random_request();
		int         pick;
		logic [1:0] cmd;
		logic [7:0] ch;
		logic [4:0] col, row;
		pick = $urandom_range(0, 99);
		if (pick < 68) cmd = CMD_PRINT;
		else if (pick < 80) cmd = CMD_BKSP;
		else if (pick < 82) cmd = CMD_CLEAR;
		else cmd = CMD_PEEK;
		pick = $urandom_range(0, 99);
		if (pick < 55) ch = 8'($urandom_range(32, 127));
		else if (pick < 70) ch = CH_NEWLINE;
		else ch = 8'($urandom);
		// Half of the reads land inside the window, where text lives.
		if ($urandom_range(0, 1)) begin
			col = regs.left + 5'($urandom_range(0, clamp_size(regs.cols) - 1));
			row = regs.top + 5'($urandom_range(0, clamp_size(regs.rows) - 1));
		end else begin
			col = 5'($urandom);
			row = 5'($urandom);
		end
		return make_request(cmd, ch, col, row);
	endfunction

	// Waits until every request has been sent and answered.
	task automatic drain();
		do @(negedge clk);
		while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] index, logic [7:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (index)
			REG_LEFT: regs.left = value[4:0];
			REG_TOP:  regs.top = value[4:0];
			REG_COLS: regs.cols = value[5:0];
			REG_ROWS: regs.rows = value[5:0];
			REG_FONT: regs.font = value;
			default:  regs.attr = value;
		endcase
	endtask

	task automatic write_all(logic [7:0] l, logic [7:0] t, logic [7:0] c,
		logic [7:0] r, logic [7:0] f, logic [7:0] a);
		write_reg(REG_LEFT, l);
		write_reg(REG_TOP, t);
		write_reg(REG_COLS, c);
		write_reg(REG_ROWS, r);
		write_reg(REG_FONT, f);
		write_reg(REG_ATTR, a);
	endtask

	initial begin
		for (int i = 0; i < 1024; i++) map_cells[i] = '0;
		cur_col = 0;
		cur_row = 0;
		regs.left = 0;
		regs.top = 0;
		regs.cols = 20;
		regs.rows = 16;
		regs.font = 0;
		regs.attr = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset settings: letter folding, the ends of
		// the printable range, the zero byte, ignored control and high bytes,
		// reads at the map corners, backspace at the top-left corner, and a
		// run of newlines that forces a scroll.
		pending_requests.push_back(make_request(CMD_PRINT, "a", 0, 0));
		pending_requests.push_back(make_request(CMD_PRINT, "z", 0, 0));
		pending_requests.push_back(make_request(CMD_PRINT, "A", 0, 0));
		pending_requests.push_back(make_request(CMD_PRINT, CH_SPACE, 0, 0));
		pending_requests.push_back(make_request(CMD_PRINT, CH_LAST, 0, 0));
		pending_requests.push_back(make_request(CMD_PRINT, 8'h00, 0, 0));
		pending_requests.push_back(make_request(CMD_PRINT, 8'h01, 0, 0));
		pending_requests.push_back(make_request(CMD_PRINT, 8'h80, 0, 0));
		pending_requests.push_back(make_request(CMD_PRINT, 8'hFF, 0, 0));
		pending_requests.push_back(make_request(CMD_PEEK, 0, 0, 0));
		pending_requests.push_back(make_request(CMD_PEEK, 0, 4, 0));
		pending_requests.push_back(make_request(CMD_PEEK, 8'hFF, 31, 31));
		pending_requests.push_back(make_request(CMD_PRINT, CH_NEWLINE, 0, 0));
		pending_requests.push_back(make_request(CMD_BKSP, 0, 0, 0));
		pending_requests.push_back(make_request(CMD_BKSP, 0, 0, 0));
		pending_requests.push_back(make_request(CMD_CLEAR, 0, 0, 0));
		pending_requests.push_back(make_request(CMD_BKSP, 0, 0, 0));
		for (int i = 0; i < 16; i++)
			pending_requests.push_back(make_request(CMD_PRINT, CH_NEWLINE, 0, 0));
		pending_requests.push_back(make_request(CMD_PRINT, "q", 0, 0));
		pending_requests.push_back(make_request(CMD_PEEK, 0, 0, 15));
		drain();

		// Random phases, each under its own register settings. Fixed settings,
		// among them the extremes of every register, come first, then random ones.
		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: write_all(31, 31, 32, 32, 255, 255);
				1: write_all(0, 0, 1, 1, 0, 0);
				2: write_all(30, 29, 0, 0, 8'h5A, 8'hA5);
				3: write_all(3, 7, 63, 63, 8'h80, 8'h7F);
				4: write_all(17, 2, 5, 3, 8'h41, 8'h01);
				default: write_all(8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)),
					8'($urandom_range(1, 12)), 8'($urandom_range(1, 8)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			endcase
			no_idle = (phase % 4 == 3);
			for (int i = 0; i < 68; i++)
				pending_requests.push_back(random_request());
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#10000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+sv
sv/twc_pkg.sv
sv/twc_cell_ram.sv
sv/twc_seq.sv
sv/text_window_console_unit.sv
dv/text_window_console_unit_test.sv
